// ===== rtl/core/fat12ccw_pkg.sv =====
// Shared constants and types for the FAT12 cluster chain walker.
// No dependencies.
package fat12ccw_pkg;

  localparam int unsigned TABLE_BYTES = 8192;
  localparam int unsigned TableAw     = $clog2(TABLE_BYTES);

  localparam int unsigned LbaW     = 24;
  localparam int unsigned ClusterW = 12;
  localparam int unsigned SpcW     = 8;
  localparam int unsigned IdxW     = 7;
  localparam int unsigned AddrW    = 13;
  localparam int unsigned PosW     = 13;

  localparam logic [ClusterW-1:0] EocMark  = 12'hFF8;
  localparam logic [ClusterW-1:0] EntryMsk = 12'hFFF;
  localparam int unsigned         OddShift = 4;
  localparam logic [SpcW-1:0]     SpcMax   = 8'd128;

  typedef enum logic [1:0] {
    KindLoad    = 2'd0,
    KindOpen    = 2'd1,
    KindAdvance = 2'd2,
    KindUnused  = 2'd3
  } kind_e;

  typedef enum logic {
    CfgSpc       = 1'b0,
    CfgDataStart = 1'b1
  } cfg_idx_e;

endpackage

// ===== rtl/core/fat12_cluster_chain_walker_core.sv =====
// Steps: open, or advance within a cluster, runs the multiply and then registers the result;
// advance onto the next cluster first makes two reads of the table's single read port, then multiplies.
// Input ready only while idle, so a new transaction is taken only once the last is through;
// a pending result does not block the next transaction until its own result is ready.
// Reset: sectors_per_cluster 1, data_start_lba 0, cluster 0, sector index 0; the FAT table
// holds no defined contents until loaded.
module fat12_cluster_chain_walker_core
  import fat12ccw_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [LbaW-1:0]     cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          kind_i,
  input  logic [AddrW-1:0]    fat_address_i,
  input  logic [7:0]          fat_byte_i,
  input  logic [ClusterW-1:0] first_cluster_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [LbaW-1:0]     sector_lba_o,
  output logic [ClusterW-1:0] cluster_o,
  output logic                end_of_chain_o
);

  typedef enum logic [2:0] {
    StIdle,
    StRdLo,
    StRdHi,
    StNext,
    StMul,
    StFin
  } state_e;

  state_e              state_q;
  logic [SpcW-1:0]     spc_q;
  logic [LbaW-1:0]     data_start_q;
  logic [ClusterW-1:0] cur_q;
  logic [IdxW-1:0]     idx_q;
  logic [7:0]          lo_q;
  logic                rd_ok_q;
  logic                lo_ok_q;
  logic [LbaW-1:0]     prod_q;
  logic                out_valid_q;
  logic [LbaW-1:0]     lba_q;
  logic [ClusterW-1:0] cl_q;
  logic                eoc_q;

  logic [7:0]          mem [TABLE_BYTES];
  logic [7:0]          rd_data_q;

  logic                accept;
  logic                wr_en;
  logic [PosW-1:0]     pos;
  logic [PosW-1:0]     rd_pos;
  logic [SpcW-1:0]     spc_eff;
  logic [SpcW-1:0]     idx_inc;
  logic                cur_eoc;
  logic [15:0]         half;
  logic [ClusterW-1:0] next_cl;
  logic [LbaW-1:0]     diff;
  logic [LbaW-1:0]     sum;
  logic                out_free;

  assign accept   = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == StIdle);
  assign wr_en    = accept && (kind_e'(kind_i) == KindLoad)
                    && (32'(fat_address_i) < TABLE_BYTES);

  assign pos      = PosW'(cur_q) + PosW'(cur_q >> 1);
  assign rd_pos   = (state_q == StRdHi) ? pos + PosW'(1) : pos;

  always_comb begin
    if (spc_q == '0) begin
      spc_eff = SpcW'(1);
    end else if (spc_q > SpcMax) begin
      spc_eff = SpcMax;
    end else begin
      spc_eff = spc_q;
    end
  end

  assign idx_inc  = SpcW'(idx_q) + SpcW'(1);
  assign cur_eoc  = (cur_q >= EocMark);
  assign half     = {(rd_ok_q ? rd_data_q : 8'd0), (lo_ok_q ? lo_q : 8'd0)};
  assign next_cl  = cur_q[0] ? (ClusterW'(half >> OddShift) & EntryMsk)
                             : (half[ClusterW-1:0] & EntryMsk);
  assign diff     = LbaW'(cur_q) - LbaW'(2);
  assign sum      = data_start_q + prod_q + LbaW'(idx_q);
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[TableAw'(fat_address_i)] <= fat_byte_i;
    end
    rd_data_q <= mem[TableAw'(rd_pos)];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      spc_q        <= SpcW'(1);
      data_start_q <= '0;
      cur_q        <= '0;
      idx_q        <= '0;
      lo_q         <= '0;
      rd_ok_q      <= 1'b0;
      lo_ok_q      <= 1'b0;
      prod_q       <= '0;
      out_valid_q  <= 1'b0;
      lba_q        <= '0;
      cl_q         <= '0;
      eoc_q        <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CfgSpc:       spc_q        <= cfg_wdata_i[SpcW-1:0];
          CfgDataStart: data_start_q <= cfg_wdata_i;
          default:      ;
        endcase
      end

      if (out_valid_q && out_ready_i && (state_q != StFin)) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        StIdle: begin
          if (accept) begin
            case (kind_e'(kind_i))
              KindOpen: begin
                cur_q   <= first_cluster_i;
                idx_q   <= '0;
                state_q <= StMul;
              end
              KindAdvance: begin
                if (cur_eoc) begin
                  state_q <= StMul;
                end else if (idx_inc >= spc_eff) begin
                  state_q <= StRdLo;
                end else begin
                  idx_q   <= idx_inc[IdxW-1:0];
                  state_q <= StMul;
                end
              end
              default: ;
            endcase
          end
        end
        StRdLo: begin
          rd_ok_q <= (32'(pos) < TABLE_BYTES);
          state_q <= StRdHi;
        end
        StRdHi: begin
          lo_q    <= rd_data_q;
          lo_ok_q <= rd_ok_q;
          rd_ok_q <= (32'(pos) + 32'd1 < TABLE_BYTES);
          state_q <= StNext;
        end
        StNext: begin
          cur_q   <= next_cl;
          idx_q   <= '0;
          state_q <= StMul;
        end
        StMul: begin
          prod_q  <= LbaW'(diff * LbaW'(spc_eff));
          state_q <= StFin;
        end
        StFin: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            lba_q       <= cur_eoc ? '0 : sum;
            cl_q        <= cur_q;
            eoc_q       <= cur_eoc;
            state_q     <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sector_lba_o   = lba_q;
  assign cluster_o      = cl_q;
  assign end_of_chain_o = eoc_q;

endmodule
